// ===== rtl/core/dcd_pkg.sv =====
// Shared types, constants and the motion table for the drive command decoder.
package dcd_pkg;

	// Field widths
	localparam int MODE_W    = 4;
	localparam int VALUE_W   = 12;
	localparam int SPEED_W   = 12;
	localparam int MAG_W     = 7;
	localparam int STEER_W   = 8;
	localparam int S_DATA_W  = 16;
	localparam int M_DATA_W  = 40;

	// Command classes
	localparam logic [MODE_W-1:0] MODE_STEER  = 4'd1;
	localparam logic [MODE_W-1:0] MODE_MOTION = 4'd2;
	localparam logic [MODE_W-1:0] MODE_SPEED  = 4'd4;

	// Motion codes
	localparam logic [VALUE_W-1:0] MOT_FWD       = 12'd1;
	localparam logic [VALUE_W-1:0] MOT_REV       = 12'd2;
	localparam logic [VALUE_W-1:0] MOT_SPIN_L    = 12'd4;
	localparam logic [VALUE_W-1:0] MOT_FWD_L     = 12'd5;
	localparam logic [VALUE_W-1:0] MOT_REV_L     = 12'd6;
	localparam logic [VALUE_W-1:0] MOT_SPIN_R    = 12'd8;
	localparam logic [VALUE_W-1:0] MOT_FWD_R     = 12'd9;
	localparam logic [VALUE_W-1:0] MOT_REV_R     = 12'd10;
	localparam logic [VALUE_W-1:0] MOT_STOP      = 12'd16;

	// Horn requests
	localparam logic [1:0] HORN_NONE  = 2'd0;
	localparam logic [1:0] HORN_MUTE  = 2'd1;
	localparam logic [1:0] HORN_PULSE = 2'd2;

	// Steering and speed constants
	localparam logic [7:0]  SPEED_RESET  = 8'd50;
	localparam logic [12:0] STEER_CENTER = 13'd100;
	localparam logic [6:0]  STEER_FULL   = 7'd100;
	// x/25 == (x*RECIP_25) >> RECIP_SHIFT, exact for x < 2^22/21
	localparam logic [17:0] RECIP_25     = 18'd167773;
	localparam int          RECIP_SHIFT  = 22;

	// Wheel direction: 1 forward, -1 reverse, 0 stopped
	typedef logic signed [1:0] dir_t;

	localparam dir_t D_FWD  = 2'sb01;
	localparam dir_t D_STOP = 2'sb00;
	localparam dir_t D_REV  = 2'sb11;

	typedef struct packed {
		dir_t lf;
		dir_t lr;
		dir_t rf;
		dir_t rr;
	} dirs_t;

	typedef struct packed {
		logic       hit;
		dirs_t      dirs;
		logic [1:0] horn;
	} motion_t;

	// Stage 2 snapshot handed to the speed reduction stages
	typedef struct packed {
		dirs_t            dirs;
		logic [1:0]       horn;
		logic [SPEED_W-1:0] speed;
		logic [MAG_W-1:0] mag;
		logic             steer_neg;
		logic             steer_pos;
	} snap_t;

	// Motion code lookup
	function automatic motion_t motion_lookup(input logic [VALUE_W-1:0] code);
		motion_t r;
		r.hit  = 1'b1;
		r.dirs = '{D_STOP, D_STOP, D_STOP, D_STOP};
		r.horn = HORN_MUTE;
		case (code)
			MOT_FWD:    r.dirs = '{D_FWD,  D_FWD,  D_FWD,  D_FWD};
			MOT_REV: begin
				r.dirs = '{D_REV,  D_REV,  D_REV,  D_REV};
				r.horn = HORN_PULSE;
			end
			MOT_SPIN_L: r.dirs = '{D_REV,  D_REV,  D_FWD,  D_FWD};
			MOT_FWD_L:  r.dirs = '{D_FWD,  D_STOP, D_FWD,  D_FWD};
			MOT_REV_L: begin
				r.dirs = '{D_STOP, D_REV,  D_REV,  D_REV};
				r.horn = HORN_PULSE;
			end
			MOT_SPIN_R: r.dirs = '{D_FWD,  D_FWD,  D_REV,  D_REV};
			MOT_FWD_R:  r.dirs = '{D_FWD,  D_FWD,  D_FWD,  D_STOP};
			MOT_REV_R: begin
				r.dirs = '{D_REV,  D_REV,  D_STOP, D_REV};
				r.horn = HORN_PULSE;
			end
			MOT_STOP:   r.dirs = '{D_STOP, D_STOP, D_STOP, D_STOP};
			default: begin
				r.hit  = 1'b0;
				r.horn = HORN_NONE;
			end
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/dcd_state.sv =====
// Command decode stage: updates directions, speed and steering, registers a snapshot.
module dcd_state #(
	parameter int SPD_BITS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [dcd_pkg::MODE_W-1:0]  in_mode,
	input  logic [SPD_BITS-1:0]         in_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output dcd_pkg::snap_t              out_snap
);
	import dcd_pkg::*;

	logic [SPD_BITS-1:0]      speed_q;
	logic signed [STEER_W-1:0] steer_q;
	dirs_t                    dirs_q;

	logic                     v_s2;
	snap_t                    snap_s2;

	logic                     adv;
	logic [VALUE_W-1:0]       val_ext;
	motion_t                  mot;
	logic signed [12:0]       steer_raw;
	logic signed [STEER_W-1:0] steer_sat;
	logic [SPD_BITS-1:0]      speed_nx;
	logic signed [STEER_W-1:0] steer_nx;
	dirs_t                    dirs_nx;
	logic [1:0]               horn_nx;
	logic [STEER_W-1:0]       steer_abs;

	assign adv      = !v_s2 || out_ready;
	assign in_ready = adv;
	assign val_ext  = VALUE_W'(in_value);
	assign mot      = motion_lookup(val_ext);

	// Steering: value minus center, clamped to +/-100
	assign steer_raw = $signed({1'b0, val_ext}) - $signed(STEER_CENTER);

	always_comb begin
		if (steer_raw > 13'sd100) begin
			steer_sat = 8'sd100;
		end else if (steer_raw < -13'sd100) begin
			steer_sat = -8'sd100;
		end else begin
			steer_sat = steer_raw[STEER_W-1:0];
		end
	end

	// Next state for this command
	always_comb begin
		speed_nx = speed_q;
		steer_nx = steer_q;
		dirs_nx  = dirs_q;
		horn_nx  = HORN_NONE;
		case (in_mode)
			MODE_MOTION: begin
				if (mot.hit) begin
					dirs_nx = mot.dirs;
				end
				horn_nx = mot.horn;
			end
			MODE_SPEED: speed_nx = in_value;
			MODE_STEER: steer_nx = steer_sat;
			default: ;
		endcase
	end

	assign steer_abs = steer_nx[STEER_W-1] ? STEER_W'(-steer_nx) : STEER_W'(steer_nx);

	// Architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= SPD_BITS'(SPEED_RESET);
			steer_q <= '0;
			dirs_q  <= '{D_STOP, D_STOP, D_STOP, D_STOP};
		end else if (in_valid && adv) begin
			speed_q <= speed_nx;
			steer_q <= steer_nx;
			dirs_q  <= dirs_nx;
		end
	end

	// Stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= in_valid;
		end
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		if (in_valid && adv) begin
			snap_s2.dirs      <= dirs_nx;
			snap_s2.horn      <= horn_nx;
			snap_s2.speed     <= SPEED_W'(speed_nx);
			snap_s2.mag       <= steer_abs[MAG_W-1:0];
			snap_s2.steer_neg <= steer_nx[STEER_W-1];
			snap_s2.steer_pos <= !steer_nx[STEER_W-1] && (steer_nx != '0);
		end
	end

	assign out_valid = v_s2;
	assign out_snap  = snap_s2;

endmodule

// ===== rtl/core/dcd_speed.sv =====
// Steering reduction: speed*(100-|steer|) then an exact divide by 100, two stages.
module dcd_speed #(
	parameter int SPD_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  dcd_pkg::snap_t               in_snap,
	output logic                         out_valid,
	input  logic                         out_ready,
	output dcd_pkg::dirs_t               out_dirs,
	output logic [1:0]                   out_horn,
	output logic [dcd_pkg::SPEED_W-1:0]  out_left,
	output logic [dcd_pkg::SPEED_W-1:0]  out_right
);
	import dcd_pkg::*;

	localparam int PROD_W = SPD_BITS + MAG_W;
	localparam int QUART_W = PROD_W - 2;
	localparam int RPROD_W = QUART_W + 18;

	logic                v_s3, v_s4;
	logic                adv3, adv4;
	logic [PROD_W-1:0]   prod_s3;
	snap_t               snap_s3;
	logic [RPROD_W-1:0]  rprod;
	logic [SPD_BITS-1:0] reduced;
	logic [SPEED_W-1:0]  left_nx, right_nx;
	logic [SPEED_W-1:0]  left_s4, right_s4;
	dirs_t               dirs_s4;
	logic [1:0]          horn_s4;

	assign adv4     = !v_s4 || out_ready;
	assign adv3     = !v_s3 || adv4;
	assign in_ready = adv3;

	// Divide by 100 as (p/4)/25 via reciprocal
	assign rprod   = RPROD_W'(prod_s3[PROD_W-1:2]) * RPROD_W'(RECIP_25);
	assign reduced = rprod[RECIP_SHIFT +: SPD_BITS];

	always_comb begin
		left_nx  = snap_s3.speed;
		right_nx = snap_s3.speed;
		if (snap_s3.steer_neg) begin
			left_nx = SPEED_W'(reduced);
		end else if (snap_s3.steer_pos) begin
			right_nx = SPEED_W'(reduced);
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv3) v_s3 <= in_valid;
			if (adv4) v_s4 <= v_s3;
		end
	end

	// Stage 3: product
	always_ff @(posedge clk) begin
		if (in_valid && adv3) begin
			snap_s3 <= in_snap;
			prod_s3 <= PROD_W'(in_snap.speed[SPD_BITS-1:0]) *
				PROD_W'(STEER_FULL - in_snap.mag);
		end
	end

	// Stage 4: result register
	always_ff @(posedge clk) begin
		if (v_s3 && adv4) begin
			dirs_s4  <= snap_s3.dirs;
			horn_s4  <= snap_s3.horn;
			left_s4  <= left_nx;
			right_s4 <= right_nx;
		end
	end

	assign out_valid = v_s4;
	assign out_dirs  = dirs_s4;
	assign out_horn  = horn_s4;
	assign out_left  = left_s4;
	assign out_right = right_s4;

endmodule

// ===== rtl/core/drive_command_decoder.sv =====
// Drive command decoder top level: input register, decode stage, speed reduction stages.
// Pipeline from input transaction to result on m_tvalid: input register,
//   decode/state stage, multiply stage, reciprocal-divide result register.
// Throughput: one command per cycle; each stage holds one transaction and stalls
//   only when the stage after it is full and not taking.
// Reset: arst_n clears all valid bits; speed resets to 50, steering to 0, wheels stopped.
module drive_command_decoder #(
	parameter int VALUE_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [3:0] mode, [15:4] value
	input  logic [15:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [1:0] dir_left_front, [3:2] dir_left_rear, [5:4] dir_right_front,
	// [7:6] dir_right_rear, [19:8] left_speed, [31:20] right_speed,
	// [33:32] horn_action, [39:34] zero
	output logic [39:0] m_tdata
);
	import dcd_pkg::*;

	localparam int SPD_BITS = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

	logic                v_s1;
	logic [MODE_W-1:0]   mode_s1;
	logic [SPD_BITS-1:0] value_s1;
	logic                rdy2, adv1;
	logic                v2;
	logic                rdy3;
	snap_t               snap2;
	dirs_t               dirs_o;
	logic [1:0]          horn_o;
	logic [SPEED_W-1:0]  left_o, right_o;

	assign adv1     = !v_s1 || rdy2;
	assign s_tready = adv1;

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= s_tvalid;
		end
	end

	// Input register payload, value masked to VALUE_BITS
	always_ff @(posedge clk) begin
		if (s_tvalid && adv1) begin
			mode_s1  <= s_tdata[MODE_W-1:0];
			value_s1 <= s_tdata[MODE_W +: SPD_BITS];
		end
	end

	dcd_state #(.SPD_BITS(SPD_BITS)) u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (rdy2),
		.in_mode   (mode_s1),
		.in_value  (value_s1),
		.out_valid (v2),
		.out_ready (rdy3),
		.out_snap  (snap2)
	);

	dcd_speed #(.SPD_BITS(SPD_BITS)) u_speed (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v2),
		.in_ready  (rdy3),
		.in_snap   (snap2),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_dirs  (dirs_o),
		.out_horn  (horn_o),
		.out_left  (left_o),
		.out_right (right_o)
	);

	// Result packing
	assign m_tdata = {6'b0, horn_o, right_o, left_o,
		dirs_o.rr, dirs_o.rf, dirs_o.lr, dirs_o.lf};

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the drive command decoder stream block.
module tb;
	import dcd_pkg::*;

	// Command classes that the decoder ignores
	localparam logic [MODE_W-1:0] MODE_NOP_LO  = 4'd0;
	localparam logic [MODE_W-1:0] MODE_NOP_MID = 4'd3;
	localparam logic [MODE_W-1:0] MODE_NOP_HI  = 4'd15;
	// Motion codes missing from the table
	localparam logic [VALUE_W-1:0] MOT_NONE    = 12'd0;
	localparam logic [VALUE_W-1:0] MOT_HOLE    = 12'd3;
	localparam logic [VALUE_W-1:0] MOT_ALL_ONE = 12'hfff;
	// Steering arrives biased by 100 and is clamped to +/-100
	localparam int STEER_BIAS  = 100;
	localparam int STEER_LIMIT = 100;
	localparam int RANDOM_CMDS = 950;
	localparam int PRINT_CAP   = 40;

	typedef struct {
		logic [MODE_W-1:0]  mode;
		logic [VALUE_W-1:0] value;
		bit                 drain;
	} drive_cmd_t;

	typedef struct {
		dirs_t              dirs;
		logic [SPEED_W-1:0] left_speed;
		logic [SPEED_W-1:0] right_speed;
		logic [1:0]         horn;
	} drive_out_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [15:0]        s_tdata = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [39:0]        m_tdata;

	drive_cmd_t         cmd_q[$];
	drive_out_t         drive_out_q[$];
	int                 err_count = 0;
	int                 cmds_taken = 0;
	bit                 cmd_taken = 1'b0;

	// Shadow of the decoder state
	logic [SPEED_W-1:0] drv_speed = SPEED_W'(SPEED_RESET);
	int                 drv_steer = 0;
	dirs_t              drv_dirs = '{D_STOP, D_STOP, D_STOP, D_STOP};

	logic [VALUE_W-1:0] motion_codes[9] = '{MOT_FWD, MOT_REV, MOT_SPIN_L, MOT_FWD_L,
		MOT_REV_L, MOT_SPIN_R, MOT_FWD_R, MOT_REV_R, MOT_STOP};

	drive_command_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#400000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (err_count < PRINT_CAP)
			$display("ERROR @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	// Apply one command to the shadow state and return the drive outputs it yields
	function automatic drive_out_t decode_drive(input logic [MODE_W-1:0] mode,
			input logic [VALUE_W-1:0] value);
		drive_out_t r;
		int         steer_mag;
		int         reduced;
		r.horn = HORN_NONE;
		if (mode == MODE_MOTION) begin
			case (value)
				MOT_FWD: begin
					drv_dirs = '{D_FWD, D_FWD, D_FWD, D_FWD};
					r.horn = HORN_MUTE;
				end
				MOT_REV: begin
					drv_dirs = '{D_REV, D_REV, D_REV, D_REV};
					r.horn = HORN_PULSE;
				end
				MOT_SPIN_L: begin
					drv_dirs = '{D_REV, D_REV, D_FWD, D_FWD};
					r.horn = HORN_MUTE;
				end
				MOT_FWD_L: begin
					drv_dirs = '{D_FWD, D_STOP, D_FWD, D_FWD};
					r.horn = HORN_MUTE;
				end
				MOT_REV_L: begin
					drv_dirs = '{D_STOP, D_REV, D_REV, D_REV};
					r.horn = HORN_PULSE;
				end
				MOT_SPIN_R: begin
					drv_dirs = '{D_FWD, D_FWD, D_REV, D_REV};
					r.horn = HORN_MUTE;
				end
				MOT_FWD_R: begin
					drv_dirs = '{D_FWD, D_FWD, D_FWD, D_STOP};
					r.horn = HORN_MUTE;
				end
				MOT_REV_R: begin
					drv_dirs = '{D_REV, D_REV, D_STOP, D_REV};
					r.horn = HORN_PULSE;
				end
				MOT_STOP: begin
					drv_dirs = '{D_STOP, D_STOP, D_STOP, D_STOP};
					r.horn = HORN_MUTE;
				end
				default: ;
			endcase
		end else if (mode == MODE_SPEED) begin
			drv_speed = value;
		end else if (mode == MODE_STEER) begin
			drv_steer = int'(value) - STEER_BIAS;
			if (drv_steer > STEER_LIMIT)
				drv_steer = STEER_LIMIT;
			if (drv_steer < -STEER_LIMIT)
				drv_steer = -STEER_LIMIT;
		end
		// Slow the side the steering points to
		steer_mag = (drv_steer < 0) ? -drv_steer : drv_steer;
		reduced = (int'(drv_speed) * (STEER_LIMIT - steer_mag)) / STEER_LIMIT;
		r.dirs = drv_dirs;
		r.left_speed = drv_speed;
		r.right_speed = drv_speed;
		if (drv_steer < 0)
			r.left_speed = reduced[SPEED_W-1:0];
		else if (drv_steer > 0)
			r.right_speed = reduced[SPEED_W-1:0];
		return r;
	endfunction

	// Sender: bursts of commands with random gaps; a drain mark waits for an empty pipe
	int burst_left = 4;
	int gap_left = 0;
	always @(negedge clk) begin
		bit offer;
		if (arst_n && (!s_tvalid || cmd_taken)) begin
			offer = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (cmd_q.size() > 0 && !(cmd_q[0].drain && drive_out_q.size() > 0)) begin
				offer = 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 32);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
			s_tvalid <= offer;
			if (offer)
				s_tdata <= {cmd_q[0].value, cmd_q[0].mode};
			else
				s_tdata <= 16'($urandom);
		end
	end

	// Receiver: stall style is redrawn periodically; two long hold-offs mid run
	int rx_cycle = 0;
	int rx_style = 0;
	int hold_left = 0;
	int holds_done = 0;
	always @(negedge clk) begin
		bit rdy;
		if (arst_n) begin
			rx_cycle++;
			if (rx_cycle % 128 == 0)
				rx_style = $urandom_range(0, 3);
			if (hold_left == 0 && holds_done < 2 && cmds_taken >= (holds_done == 0 ? 200 : 600)) begin
				hold_left = 400;
				holds_done++;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				case (rx_style)
					0: rdy = 1'b1;
					1: rdy = 1'($urandom_range(0, 1));
					2: rdy = ($urandom_range(0, 3) != 0);
					default: rdy = (rx_cycle % 5 != 0);
				endcase
			end
			m_tready <= rdy;
		end
	end

	// Monitor: predict on each input transaction, check each output transaction
	always @(posedge clk) begin
		drive_out_t got;
		drive_out_t want;
		if (arst_n) begin
			cmd_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				drive_out_q.push_back(decode_drive(s_tdata[3:0], s_tdata[15:4]));
				cmd_q.delete(0);
				cmds_taken++;
			end
			if (m_tvalid && m_tready) begin
				got.dirs.lf = m_tdata[1:0];
				got.dirs.lr = m_tdata[3:2];
				got.dirs.rf = m_tdata[5:4];
				got.dirs.rr = m_tdata[7:6];
				got.left_speed = m_tdata[19:8];
				got.right_speed = m_tdata[31:20];
				got.horn = m_tdata[33:32];
				if (drive_out_q.size() == 0) begin
					report_mismatch($sformatf("result with none expected, tdata=%h", m_tdata));
				end else begin
					want = drive_out_q.pop_front();
					if (got.dirs.lf !== want.dirs.lf)
						report_mismatch($sformatf("dir_left_front %0d exp %0d",
							got.dirs.lf, want.dirs.lf));
					if (got.dirs.lr !== want.dirs.lr)
						report_mismatch($sformatf("dir_left_rear %0d exp %0d",
							got.dirs.lr, want.dirs.lr));
					if (got.dirs.rf !== want.dirs.rf)
						report_mismatch($sformatf("dir_right_front %0d exp %0d",
							got.dirs.rf, want.dirs.rf));
					if (got.dirs.rr !== want.dirs.rr)
						report_mismatch($sformatf("dir_right_rear %0d exp %0d",
							got.dirs.rr, want.dirs.rr));
					if (got.left_speed !== want.left_speed)
						report_mismatch($sformatf("left_speed %0d exp %0d",
							got.left_speed, want.left_speed));
					if (got.right_speed !== want.right_speed)
						report_mismatch($sformatf("right_speed %0d exp %0d",
							got.right_speed, want.right_speed));
					if (got.horn !== want.horn)
						report_mismatch($sformatf("horn_action %0d exp %0d",
							got.horn, want.horn));
					if (m_tdata[39:34] !== '0)
						report_mismatch($sformatf("pad bits %b not zero", m_tdata[39:34]));
				end
			end
		end
	end

	// Stimulus: directed corners first, then weighted random commands
	initial begin
		drive_cmd_t c;
		int pick;
		c.drain = 1'b0;
		c = '{MODE_NOP_LO, MOT_NONE, 1'b0};      cmd_q.push_back(c);
		c = '{MODE_SPEED, 12'hfff, 1'b0};       cmd_q.push_back(c);
		c = '{MODE_STEER, 12'd0, 1'b0};         cmd_q.push_back(c);
		c = '{MODE_STEER, 12'hfff, 1'b0};       cmd_q.push_back(c);
		c = '{MODE_STEER, 12'd37, 1'b0};        cmd_q.push_back(c);
		c = '{MODE_STEER, 12'd200, 1'b0};       cmd_q.push_back(c);
		c = '{MODE_STEER, 12'd201, 1'b0};       cmd_q.push_back(c);
		foreach (motion_codes[i]) begin
			c = '{MODE_MOTION, motion_codes[i], 1'b0};
			cmd_q.push_back(c);
		end
		c = '{MODE_MOTION, MOT_NONE, 1'b0};     cmd_q.push_back(c);
		c = '{MODE_MOTION, MOT_HOLE, 1'b0};     cmd_q.push_back(c);
		c = '{MODE_MOTION, MOT_ALL_ONE, 1'b0};  cmd_q.push_back(c);
		c = '{MODE_NOP_HI, 12'hfff, 1'b0};      cmd_q.push_back(c);
		c = '{MODE_NOP_MID, 12'h5a5, 1'b0};     cmd_q.push_back(c);
		c = '{MODE_SPEED, 12'd0, 1'b0};         cmd_q.push_back(c);
		c = '{MODE_STEER, 12'd100, 1'b0};       cmd_q.push_back(c);
		c = '{MODE_SPEED, 12'd1234, 1'b0};      cmd_q.push_back(c);

		for (int n = 0; n < RANDOM_CMDS; n++) begin
			pick = $urandom_range(0, 99);
			c.drain = (n == 350 || n == 800);
			if (pick < 35) begin
				c.mode = MODE_MOTION;
				if ($urandom_range(0, 4) != 0)
					c.value = motion_codes[$urandom_range(0, 8)];
				else
					c.value = VALUE_W'($urandom);
			end else if (pick < 55) begin
				c.mode = MODE_SPEED;
				case ($urandom_range(0, 4))
					0: c.value = $urandom_range(0, 1) ? 12'hfff : 12'd0;
					1, 2: c.value = VALUE_W'($urandom_range(0, 255));
					default: c.value = VALUE_W'($urandom);
				endcase
			end else if (pick < 85) begin
				c.mode = MODE_STEER;
				if ($urandom_range(0, 5) != 0)
					c.value = VALUE_W'($urandom_range(0, 2 * STEER_BIAS));
				else
					c.value = VALUE_W'($urandom);
			end else begin
				do
					c.mode = MODE_W'($urandom);
				while (c.mode == MODE_MOTION || c.mode == MODE_SPEED || c.mode == MODE_STEER);
				c.value = VALUE_W'($urandom);
			end
			cmd_q.push_back(c);
		end

		while (!arst_n || cmd_q.size() != 0 || drive_out_q.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
